/* design/u8esc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8esc_pkg
// Shared types, byte constants and classification helpers for the UTF-8
// escape character assembler.
// ----------------------------------------------------------------------------
package u8esc_pkg;

    localparam logic [7:0] BYTE_SPACE     = 8'h20;
    localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;
    localparam logic [7:0] BYTE_TAB       = 8'h09;
    localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
    localparam logic [7:0] BYTE_ASCII_MAX = 8'h7F;
    localparam logic [7:0] ESC_TAB        = 8'h74;  // 't'
    localparam logic [7:0] ESC_NEWLINE    = 8'h6E;  // 'n'
    localparam logic [7:0] ESC_HEX        = 8'h78;  // 'x'

    localparam logic [2:0] LEAD2_TAG = 3'h6;
    localparam logic [3:0] LEAD3_TAG = 4'hE;
    localparam logic [4:0] LEAD4_TAG = 5'h1E;

    // Classified byte handed from the front end to the assembler.
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] lead_len;   // 0 = invalid lead, else 1..4
        logic       is_space;   // space or newline
        logic       is_hex;
        logic [3:0] hex_val;
    } cls_byte_t;

    function automatic logic [2:0] lead_len_of(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        if (b <= BYTE_ASCII_MAX)         n = 3'd1;
        else if (b[7:5] == LEAD2_TAG)    n = 3'd2;
        else if (b[7:4] == LEAD3_TAG)    n = 3'd3;
        else if (b[7:3] == LEAD4_TAG)    n = 3'd4;
        return n;
    endfunction

    function automatic logic [4:0] hex_of(input logic [7:0] b);
        // bit 4: valid digit, bits 3:0: value
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]})      r = {1'b1, 4'(b - 8'h30)};
        else if (b inside {[8'h61:8'h66]}) r = {1'b1, 4'(b - 8'h57)};
        else if (b inside {[8'h41:8'h46]}) r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

endpackage

/* design/u8esc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8esc_front
// Front end: classifies each incoming byte (lead length, whitespace,
// hex digit) before it is queued for the assembler.
// ----------------------------------------------------------------------------
module u8esc_front
(
    input  logic [7:0]           in_byte,
    output u8esc_pkg::cls_byte_t cls
);
    import u8esc_pkg::*;

    logic [4:0] hex_info;

    assign hex_info = hex_of(in_byte);

    always_comb
    begin
        cls.data     = in_byte;
        cls.lead_len = lead_len_of(in_byte);
        cls.is_space = (in_byte == BYTE_SPACE) || (in_byte == BYTE_NEWLINE);
        cls.is_hex   = hex_info[4];
        cls.hex_val  = hex_info[3:0];
    end

endmodule

/* design/u8esc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8esc_queue
// Short FIFO of classified bytes between the front end and the assembler.
// ----------------------------------------------------------------------------
module u8esc_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  u8esc_pkg::cls_byte_t wr_data,
    output logic                 full,
    input  logic                 rd_en,
    output logic                 rd_valid,
    output u8esc_pkg::cls_byte_t rd_data
);
    import u8esc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    cls_byte_t     mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;
    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* design/u8esc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8esc_back
// Back end: escape / multibyte state machine and the registered result
// slot. Takes one classified byte per cycle whenever the slot is free or
// is being drained.
// ----------------------------------------------------------------------------
module u8esc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  u8esc_pkg::cls_byte_t q_data,
    output logic                 q_take,
    input  logic                 pop,
    output logic                 empty,
    output logic [31:0]          char_code,
    output logic                 bad_escape
);
    import u8esc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_CONT,
        PH_HEX1,
        PH_HEX2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  bytes_left_reg, bytes_left_next;
    logic [1:0]  byte_pos_reg, byte_pos_next;
    logic [31:0] code_acc_reg, code_acc_next;
    logic [3:0]  hex_high_reg, hex_high_next;
    logic        hex_high_ok_reg, hex_high_ok_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_code_reg, out_code_next;
    logic        out_bad_reg, out_bad_next;

    logic        pop_ok;
    logic        emit;
    logic [31:0] emit_code;
    logic        emit_bad;
    logic [1:0]  left_dec;
    logic [7:0]  b;

    assign pop_ok     = pop && out_valid_reg;
    assign q_take     = q_valid && (!out_valid_reg || pop);
    assign empty      = !out_valid_reg;
    assign char_code  = out_code_reg;
    assign bad_escape = out_bad_reg;
    assign b          = q_data.data;
    assign left_dec   = bytes_left_reg - 2'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        byte_pos_next    = byte_pos_reg;
        code_acc_next    = code_acc_reg;
        hex_high_next    = hex_high_reg;
        hex_high_ok_next = hex_high_ok_reg;
        emit             = 1'b0;
        emit_code        = 32'h0;
        emit_bad         = 1'b0;

        if (q_take)
        begin
            case (phase_reg)
                PH_IDLE, PH_ESC:
                begin
                    if (phase_reg == PH_IDLE && q_data.is_space)
                    begin
                        // skipped between characters
                    end
                    else if (phase_reg == PH_IDLE && b == BYTE_BACKSLASH)
                    begin
                        phase_next = PH_ESC;
                    end
                    else if (phase_reg == PH_ESC && b <= BYTE_ASCII_MAX)
                    begin
                        if (b == ESC_TAB)
                        begin
                            emit      = 1'b1;
                            emit_code = 32'(BYTE_TAB);
                        end
                        else if (b == ESC_NEWLINE)
                        begin
                            emit      = 1'b1;
                            emit_code = 32'(BYTE_NEWLINE);
                        end
                        else if (b == BYTE_BACKSLASH)
                        begin
                            emit      = 1'b1;
                            emit_code = 32'(BYTE_BACKSLASH);
                        end
                        else if (b == ESC_HEX)
                        begin
                            phase_next = PH_HEX1;
                        end
                        else
                        begin
                            emit     = 1'b1;
                            emit_bad = 1'b1;
                        end
                    end
                    else if (q_data.lead_len <= 3'd1)
                    begin
                        // single byte or invalid lead: the byte itself
                        emit      = 1'b1;
                        emit_code = 32'(b);
                    end
                    else
                    begin
                        code_acc_next   = 32'(b);
                        bytes_left_next = 2'(q_data.lead_len - 3'd1);
                        byte_pos_next   = 2'd1;
                        phase_next      = PH_CONT;
                    end
                end
                PH_CONT:
                begin
                    code_acc_next   = code_acc_reg | (32'(b) << {byte_pos_reg, 3'b000});
                    byte_pos_next   = byte_pos_reg + 2'd1;
                    bytes_left_next = left_dec;
                    if (left_dec == 2'd0)
                    begin
                        byte_pos_next = 2'd0;
                        emit          = 1'b1;
                        emit_code     = code_acc_next;
                    end
                end
                PH_HEX1:
                begin
                    hex_high_ok_next = q_data.is_hex;
                    hex_high_next    = q_data.hex_val;
                    phase_next       = PH_HEX2;
                end
                PH_HEX2:
                begin
                    emit = 1'b1;
                    if (!hex_high_ok_reg)
                    begin
                        emit_code = 32'h0;
                    end
                    else if (q_data.is_hex)
                    begin
                        emit_code = {24'h0, hex_high_reg, q_data.hex_val};
                    end
                    else
                    begin
                        emit_code = {28'h0, hex_high_reg};
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
            if (emit)
            begin
                phase_next = PH_IDLE;
            end
        end

        out_valid_next = out_valid_reg && !pop_ok;
        out_code_next  = out_code_reg;
        out_bad_next   = out_bad_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_code_next  = emit_code;
            out_bad_next   = emit_bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bytes_left_reg  <= '0;
            byte_pos_reg    <= '0;
            code_acc_reg    <= '0;
            hex_high_reg    <= '0;
            hex_high_ok_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_code_reg    <= '0;
            out_bad_reg     <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            byte_pos_reg    <= byte_pos_next;
            code_acc_reg    <= code_acc_next;
            hex_high_reg    <= hex_high_next;
            hex_high_ok_reg <= hex_high_ok_next;
            out_valid_reg   <= out_valid_next;
            out_code_reg    <= out_code_next;
            out_bad_reg     <= out_bad_next;
        end
    end

endmodule

/* design/utf8_escape_char_assembler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_escape_char_assembler
// Path: the last byte of a character passes the queue register, then the result
// slot, where the result becomes visible as long as the result slot is free.
// Throughput: one byte per cycle; the assembler takes a byte each cycle the
// result slot is free or popped, so a stalled consumer backs up the queue.
// Reset: asynchronous active low; queue empty, assembler idle, no result.
// ----------------------------------------------------------------------------
module utf8_escape_char_assembler
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        pop,
    output logic        empty,
    output logic [31:0] char_code,
    output logic        bad_escape
);
    import u8esc_pkg::*;

    cls_byte_t cls;
    cls_byte_t q_data;
    logic      q_valid;
    logic      q_take;

    u8esc_front u_front
    (
        .in_byte (in_byte),
        .cls     (cls)
    );

    u8esc_queue #(.DEPTH(DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (cls),
        .full     (full),
        .rd_en    (q_take),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    u8esc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_take     (q_take),
        .pop        (pop),
        .empty      (empty),
        .char_code  (char_code),
        .bad_escape (bad_escape)
    );

endmodule

/* design/u8esc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8esc_checker
// Port-level checks for the UTF-8 escape character assembler.
// ----------------------------------------------------------------------------
module u8esc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        pop,
    input logic        empty,
    input logic [31:0] char_code,
    input logic        bad_escape
);

    // nothing is pending once reset has been seen at an edge
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("result or full flag during reset");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(char_code) && $stable(bad_escape))
        else $error("waiting result changed");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && bad_escape |-> char_code == 32'h0)
        else $error("bad escape with nonzero code");

    // a full queue only happens behind an untaken result
    a_full_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full with no result waiting");

    // anything wider than a byte is a multibyte character with a lead in lane 0
    a_multibyte_lead: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && char_code[31:8] != 24'h0 |-> char_code[7:6] == 2'b11 && !bad_escape)
        else $error("multibyte result without lead byte");

endmodule

bind utf8_escape_char_assembler u8esc_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .char_code  (char_code),
    .bad_escape (bad_escape)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 escape character assembler. A byte
// stream goes in through the push/full side. It starts with directed
// characters and escapes, then random well-formed sequences mixed with noise.
// A scoreboard class tracks the assembler state to predict each completed
// character, then checks every beat popped from the result side in order.
// ----------------------------------------------------------------------------
module testbench;

    import u8esc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ESC,
        ST_CONT,
        ST_HEX1,
        ST_HEX2
    } asm_state_e;

    typedef struct packed {
        logic [31:0] code;
        logic        bad;
    } char_result_t;

    localparam int RANDOM_BYTES = 850;
    localparam int HOLD_CYCLES  = 400;

    // ------------------------------------------------------------------------
    // Tracks the assembler state and holds the characters still owed by the DUT
    // ------------------------------------------------------------------------
    class utf8_char_tracker;
        char_result_t expected_q[$];
        asm_state_e   state;
        logic [1:0]   left;
        logic [1:0]   lane;
        logic [31:0]  acc;
        logic [3:0]   hi;
        logic         hi_ok;
        int unsigned  n_errors;
        int unsigned  n_chars;
        int unsigned  n_multi;
        int unsigned  n_escapes;
        int unsigned  n_bad;

        function new();
            state     = ST_IDLE;
            left      = '0;
            lane      = '0;
            acc       = '0;
            hi        = '0;
            hi_ok     = 1'b0;
            n_errors  = 0;
            n_chars   = 0;
            n_multi   = 0;
            n_escapes = 0;
            n_bad     = 0;
        endfunction

        function void owe(logic [31:0] code, logic bad);
            expected_q.push_back('{code: code, bad: bad});
            state = ST_IDLE;
            n_chars++;
        endfunction

        function bit hex_digit(logic [7:0] b, output logic [3:0] v);
            v = '0;
            if (b >= "0" && b <= "9") v = 4'(b - "0");
            else if (b >= "a" && b <= "f") v = 4'(b - "a" + 10);
            else if (b >= "A" && b <= "F") v = 4'(b - "A" + 10);
            else return 1'b0;
            return 1'b1;
        endfunction

        function void begin_char(logic [7:0] b);
            int unsigned n;
            casez (b)
                8'b0???????: n = 1;
                8'b110?????: n = 2;
                8'b1110????: n = 3;
                8'b11110???: n = 4;
                default:     n = 0;
            endcase
            if (n <= 1) begin
                owe({24'd0, b}, 1'b0);
            end else begin
                acc   = {24'd0, b};
                left  = 2'(n - 1);
                lane  = 2'd1;
                state = ST_CONT;
            end
        endfunction

        // Accepted input beat: advance the state and note any completed character
        function void note_byte(logic [7:0] b);
            logic [3:0] lo;
            case (state)
                ST_ESC: begin
                    if (b > BYTE_ASCII_MAX) begin
                        begin_char(b);
                    end else if (b == ESC_HEX) begin
                        state = ST_HEX1;
                    end else begin
                        n_escapes++;
                        if (b == ESC_TAB) owe({24'd0, BYTE_TAB}, 1'b0);
                        else if (b == ESC_NEWLINE) owe({24'd0, BYTE_NEWLINE}, 1'b0);
                        else if (b == BYTE_BACKSLASH) owe({24'd0, BYTE_BACKSLASH}, 1'b0);
                        else begin
                            n_bad++;
                            owe(32'd0, 1'b1);
                        end
                    end
                end
                ST_CONT: begin
                    // continuation bytes are packed unchecked
                    acc  = acc | (32'(b) << (8 * int'(lane)));
                    lane = lane + 2'd1;
                    left = left - 2'd1;
                    if (left == 2'd0) begin
                        lane = 2'd0;
                        n_multi++;
                        owe(acc, 1'b0);
                    end
                end
                ST_HEX1: begin
                    hi_ok = hex_digit(b, hi);
                    state = ST_HEX2;
                end
                ST_HEX2: begin
                    n_escapes++;
                    if (!hi_ok) owe(32'd0, 1'b0);
                    else if (hex_digit(b, lo)) owe({24'd0, hi, lo}, 1'b0);
                    else owe({28'd0, hi}, 1'b0);
                end
                default: begin
                    if (b == BYTE_BACKSLASH) state = ST_ESC;
                    else if (b != BYTE_SPACE && b != BYTE_NEWLINE) begin_char(b);
                end
            endcase
        endfunction

        function void flag(string what, char_result_t exp_r, logic [31:0] code, logic bad);
            n_errors++;
            if (n_errors <= 10)
                $display("%0t ERROR %s: expected code=%08h bad=%0b, got code=%08h bad=%0b",
                         $time, what, exp_r.code, exp_r.bad, code, bad);
        endfunction

        // Popped result beat: compare against the oldest owed character
        function void check_char(logic [31:0] code, logic bad);
            char_result_t exp_r;
            if (expected_q.size() == 0) begin
                flag("result with nothing pending", '0, code, bad);
                return;
            end
            exp_r = expected_q.pop_front();
            if (code !== exp_r.code || bad !== exp_r.bad)
                flag("character mismatch", exp_r, code, bad);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  in_byte;
    logic        pop;
    logic        empty;
    logic [31:0] char_code;
    logic        bad_escape;

    utf8_char_tracker tracker = new();
    logic [7:0]       byte_stream[$];
    int unsigned      n_full_cycles;
    int unsigned      n_popped;
    bit               hold_done;

    utf8_escape_char_assembler i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .pop        (pop),
        .empty      (empty),
        .char_code  (char_code),
        .bad_escape (bad_escape)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3ms;
        $display("%0t timeout: result stream stalled", $time);
        $display("DONE: errors detected");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] hex_char();
        int unsigned idx;
        idx = $urandom_range(0, 21);
        if (idx < 10) return 8'("0" + idx);
        if (idx < 16) return 8'("a" + idx - 10);
        return 8'("A" + idx - 16);
    endfunction

    function automatic void add_multibyte();
        int unsigned len;
        len = $urandom_range(2, 4);
        case (len)
            2:       byte_stream.push_back({3'b110, 5'($urandom)});
            3:       byte_stream.push_back({4'b1110, 4'($urandom)});
            default: byte_stream.push_back({5'b11110, 3'($urandom)});
        endcase
        repeat (len - 1)
        begin
            if ($urandom_range(0, 9) == 0) byte_stream.push_back(8'($urandom));
            else byte_stream.push_back({2'b10, 6'($urandom)});
        end
    endfunction

    function automatic void add_escape();
        int unsigned k;
        k = $urandom_range(0, 9);
        byte_stream.push_back(BYTE_BACKSLASH);
        case (k)
            0: byte_stream.push_back(ESC_TAB);
            1: byte_stream.push_back(ESC_NEWLINE);
            2: byte_stream.push_back(BYTE_BACKSLASH);
            3, 4, 5: begin
                byte_stream.push_back(ESC_HEX);
                repeat (2)
                begin
                    if ($urandom_range(0, 4) == 0) byte_stream.push_back(8'($urandom));
                    else byte_stream.push_back(hex_char());
                end
            end
            6, 7: byte_stream.push_back(8'($urandom_range(0, 8'h7F)));
            8: add_multibyte();
            default: byte_stream.push_back(8'($urandom_range(8'h80, 8'hFF)));
        endcase
    endfunction

    function automatic void add_random_sequence();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) byte_stream.push_back(8'($urandom_range(8'h21, 8'h7E)));
        else if (r < 38) byte_stream.push_back($urandom_range(0, 1) ? BYTE_SPACE : BYTE_NEWLINE);
        else if (r < 60) add_multibyte();
        else if (r < 80) add_escape();
        else if (r < 90) begin
            if ($urandom_range(0, 1)) byte_stream.push_back({2'b10, 6'($urandom)});
            else byte_stream.push_back({5'b11111, 3'($urandom)});
        end
        else byte_stream.push_back(8'($urandom));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        bit ok;
        push    <= 1'b1;
        in_byte <= b;
        do
        begin
            @(negedge clk);
            ok = !full;
            if (!ok) n_full_cycles++;
            @(posedge clk);
        end
        while (!ok);
        tracker.note_byte(b);
    endtask

    initial
    begin
        logic [7:0]  directed[];
        int unsigned gap;
        bit          calm;
        rst_n         = 1'b0;
        push          = 1'b0;
        in_byte       = 8'h00;
        n_full_cycles = 0;
        calm          = 1'b0;
        // extremes, invalid leads, whitespace, a 4-byte char, each escape kind,
        // hex with two digits and with a non-hex first digit, unknown letter, escaped 3-byte lead
        directed = '{8'h00, 8'hFF, 8'h80, BYTE_SPACE, BYTE_NEWLINE, 8'hC3, 8'hA9,
                     8'hF0, 8'h9F, 8'h98, 8'h80,
                     BYTE_BACKSLASH, ESC_TAB, BYTE_BACKSLASH, ESC_NEWLINE,
                     BYTE_BACKSLASH, BYTE_BACKSLASH,
                     BYTE_BACKSLASH, ESC_HEX, 8'h41, 8'h66,
                     BYTE_BACKSLASH, ESC_HEX, 8'h67, 8'h30,
                     BYTE_BACKSLASH, 8'h71,
                     BYTE_BACKSLASH, 8'hE2, 8'h82, 8'hAC};
        foreach (directed[i]) byte_stream.push_back(directed[i]);
        while (byte_stream.size() < directed.size() + RANDOM_BYTES) add_random_sequence();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        foreach (byte_stream[i])
        begin
            if (i % 64 == 0) calm = ($urandom_range(0, 9) < 3);
            send_byte(byte_stream[i]);
            gap = calm ? 0 : idle_gap();
            if (gap != 0)
            begin
                push    <= 1'b0;
                in_byte <= 8'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        push <= 1'b0;

        while (tracker.expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes; checked %0d characters: %0d multibyte, %0d escapes (%0d bad).",
                 byte_stream.size(), n_popped, tracker.n_multi, tracker.n_escapes,
                 tracker.n_bad);
        $display("Input back-pressure seen on %0d cycles; %0d mismatches.",
                 n_full_cycles, tracker.n_errors);
        if (tracker.n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // result side: random pops, plus one long hold-off to back the queue up
    initial
    begin
        int unsigned idle_left;
        int unsigned hold_left;
        int unsigned cycle;
        bit          take;
        bit          calm;
        logic [31:0] code;
        logic        bad;
        pop       = 1'b0;
        idle_left = 0;
        hold_left = 0;
        cycle     = 0;
        calm      = 1'b0;
        n_popped  = 0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            take = pop && !empty;
            code = char_code;
            bad  = bad_escape;
            @(posedge clk);
            cycle++;
            if (take)
            begin
                tracker.check_char(code, bad);
                n_popped++;
            end
            if (cycle % 100 == 0) calm = ($urandom_range(0, 9) < 3);
            if (!hold_done && n_popped >= 100)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (idle_left != 0)
            begin
                idle_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (!calm) idle_left = idle_gap();
            end
        end
    end

endmodule
